### hw/rtl/matrix_multiply_4x4_top_macros.svh
// assertion macros used by the matrix multiplier top level
`ifndef MATRIX_MULTIPLY_4X4_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define MM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mmul4x4_pkg.sv
// types and codes shared by the matrix multiplier
`default_nettype none

package mmul4x4_pkg;

  // request kinds
  localparam logic [1:0] KIND_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] KIND_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] KIND_MULTIPLY   = 2'd2;

  // saturation limits of a product entry
  localparam logic [31:0] PRODUCT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PRODUCT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] product;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/matrix_multiply_4x4_top.sv
// top level of the fixed-point matrix multiplier
//
// Usage:
//   Requests arrive on req_valid / req_stall / req_data. A load request
//   writes one element of the left or right matrix (row, col, Q16.16 value);
//   loads outside the matrix and unused kinds are dropped. A multiply request
//   emits all DIM*DIM product entries on rsp_valid / rsp_stall / rsp_data in
//   row-major order, last set on the final entry.
//   Each entry runs its DIM terms through one shared 32x32 multiplier and
//   accumulator, issued in turn into the read, multiply and accumulate
//   registers; the next entry starts only after this one has been emitted.
//   req_stall stays high for the whole multiply.
//   A stalled response holds in the output register; the sequencer waits
//   before the next entry, so nothing is lost.
//   Reset clears both matrices to zero through per-entry valid bits; there
//   is no clearing pass, and requests are taken right after reset.
`default_nettype none

module matrix_multiply_4x4_top #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire mmul4x4_pkg::req_t  req_data,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output mmul4x4_pkg::rsp_t       rsp_data
);

  import mmul4x4_pkg::*;

`include "matrix_multiply_4x4_top_macros.svh"

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);
  localparam int ACC_W = 64 - FRAC_BITS + $clog2(DIM) + 1;
  localparam logic [IW-1:0] IDX_MAX = IW'(DIM - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t        state;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] k;

  logic              req_fire;
  logic              load_ok;
  logic [AW-1:0]     load_addr;
  logic [AW-1:0]     laddr;
  logic [AW-1:0]     raddr;
  logic [31:0]       lrdata;
  logic [31:0]       rrdata;
  logic [DEPTH-1:0]  lvalid;
  logic [DEPTH-1:0]  rvalid;

  logic                     s1_valid, s1_first, s1_last, s1_lv, s1_rv;
  logic                     s2_valid, s2_first, s2_last;
  logic signed [31:0]       op_a;
  logic signed [31:0]       op_b;
  logic signed [63:0]       s2_prod;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_done;
  logic [31:0]              sat;
  logic                     emit;
  logic                     final_entry;

  // request handshake and load decode
  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign load_ok   = req_fire && (req_data.kind == KIND_LOAD_LEFT ||
                                  req_data.kind == KIND_LOAD_RIGHT) &&
                     ({2'b00, req_data.row} < 4'(DIM)) &&
                     ({2'b00, req_data.col} < 4'(DIM));
  assign load_addr = AW'(req_data.row) * AW'(DIM) + AW'(req_data.col);

  // operand addresses for the current term
  assign laddr = AW'(i) * AW'(DIM) + AW'(k);
  assign raddr = AW'(k) * AW'(DIM) + AW'(j);

  mmul4x4_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (load_ok && req_data.kind == KIND_LOAD_LEFT),
    .waddr (load_addr),
    .wdata (req_data.value),
    .raddr (laddr),
    .rdata (lrdata)
  );

  mmul4x4_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (load_ok && req_data.kind == KIND_LOAD_RIGHT),
    .waddr (load_addr),
    .wdata (req_data.value),
    .raddr (raddr),
    .rdata (rrdata)
  );

  // per-entry written flags, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
      rvalid <= '0;
    end else if (load_ok) begin
      if (req_data.kind == KIND_LOAD_LEFT) begin
        lvalid[load_addr] <= 1'b1;
      end else begin
        rvalid[load_addr] <= 1'b1;
      end
    end
  end

  assign op_a = s1_lv ? $signed(lrdata) : 32'sd0;
  assign op_b = s1_rv ? $signed(rrdata) : 32'sd0;

  // product shifted down with floor rounding
  assign term = ACC_W'(s2_prod >>> FRAC_BITS);

  // saturate accumulated entry to 32 bits
  always_comb begin
    if (acc[ACC_W-1:31] == '0 || acc[ACC_W-1:31] == '1) begin
      sat = acc[31:0];
    end else if (acc[ACC_W-1]) begin
      sat = PRODUCT_MIN;
    end else begin
      sat = PRODUCT_MAX;
    end
  end

  assign final_entry = (i == IDX_MAX) && (j == IDX_MAX);
  assign emit = (state == ST_DRAIN) && acc_done && (!rsp_valid || !rsp_stall);

  // read, multiply and accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      s1_first <= (k == '0);
      s1_last  <= (k == IDX_MAX);
      s1_lv    <= lvalid[laddr];
      s1_rv    <= rvalid[raddr];
      s2_valid <= s1_valid;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_prod  <= 64'(op_a) * 64'(op_b);
      if (s2_valid) begin
        acc <= s2_first ? term : acc + term;
      end
      if (s2_valid && s2_last) begin
        acc_done <= 1'b1;
      end else if (emit) begin
        acc_done <= 1'b0;
      end
    end
  end

  // sequencer over entries and terms, plus output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !emit) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire && req_data.kind == KIND_MULTIPLY) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k == IDX_MAX) begin
            k     <= '0;
            state <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            rsp_valid        <= 1'b1;
            rsp_data.out_row <= 2'(i);
            rsp_data.out_col <= 2'(j);
            rsp_data.product <= $signed(sat);
            rsp_data.last    <= final_entry;
            if (j == IDX_MAX) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            state <= final_entry ? ST_IDLE : ST_RUN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks on sequencer and pipeline
  `MM_ASSERT_NOW(a_done_in_drain, acc_done, state == ST_DRAIN, "accumulator done outside drain")
  `MM_ASSERT_NOW(a_idle_quiet, state == ST_IDLE, !s1_valid && !s2_valid, "pipeline busy in idle")
  `MM_ASSERT_NEXT(a_pipe_flow, s1_valid, s2_valid, "read stage lost its term")
  `MM_ASSERT_NEXT(a_last_ends, emit && final_entry, state == ST_IDLE && rsp_data.last, "final entry did not end the multiply")

endmodule

`default_nettype wire

### hw/rtl/mmul4x4_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mmul4x4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### dv/matrix_multiply_4x4_top_checker.sv
// checker for the matrix multiplier: tracks both matrices and checks product entries
`default_nettype none

module matrix_multiply_4x4_top_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               req_stall,
  input  wire mmul4x4_pkg::req_t  req_data,
  input  wire logic               rsp_valid,
  input  wire logic               rsp_stall,
  input  wire mmul4x4_pkg::rsp_t  rsp_data,
  output int                      mismatch_count,
  output int                      entries_pending
);
  import mmul4x4_pkg::*;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int REPORT_MAX = 10;

  localparam logic signed [63:0] ENTRY_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] ENTRY_LO = -64'sh0000_0000_8000_0000;

  // shadow copies of the two matrices, row-major
  logic signed [31:0] left_mat  [DIM*DIM];
  logic signed [31:0] right_mat [DIM*DIM];

  // product entries still owed by the block, oldest first
  rsp_t product_queue [$];
  int   fails = 0;

  // one entry of left * right: floor-shifted terms, saturated sum
  function automatic logic signed [31:0] dot_entry(int i, int j);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      term = left_mat[i*DIM + k] * right_mat[k*DIM + j];
      acc  = acc + (term >>> FRAC_BITS);
    end
    if (acc > ENTRY_HI) return PRODUCT_MAX;
    if (acc < ENTRY_LO) return PRODUCT_MIN;
    return acc[31:0];
  endfunction

  // queue all entries of the current product in row-major order
  task automatic push_product();
    rsp_t e;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        e.out_row = i[1:0];
        e.out_col = j[1:0];
        e.product = dot_entry(i, j);
        e.last    = (i == DIM-1) && (j == DIM-1);
        product_queue.push_back(e);
      end
    end
  endtask

  // compare one accepted entry against the oldest one owed
  task automatic check_entry(rsp_t got);
    rsp_t want;
    if (product_queue.size() == 0) begin
      if (fails < REPORT_MAX)
        $display("unexpected entry: row %0d col %0d product %h last %0d",
                 got.out_row, got.out_col, got.product, got.last);
      fails++;
    end else begin
      want = product_queue.pop_front();
      if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
          got.product !== want.product || got.last !== want.last) begin
        if (fails < REPORT_MAX)
          $display("entry mismatch: exp row %0d col %0d product %h last %0d, got row %0d col %0d product %h last %0d",
                   want.out_row, want.out_col, want.product, want.last,
                   got.out_row, got.out_col, got.product, got.last);
        fails++;
      end
    end
  endtask

  // watch both channels on the clock edge
  always @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < DIM*DIM; n++) begin
        left_mat[n]  = '0;
        right_mat[n] = '0;
      end
      product_queue.delete();
    end else begin
      if (rsp_valid && !rsp_stall) check_entry(rsp_data);
      if (req_valid && !req_stall) begin
        case (req_data.kind)
          KIND_LOAD_LEFT:  left_mat[req_data.row*DIM + req_data.col]  = req_data.value;
          KIND_LOAD_RIGHT: right_mat[req_data.row*DIM + req_data.col] = req_data.value;
          KIND_MULTIPLY:   push_product();
          default: ;
        endcase
      end
    end
    mismatch_count  <= fails;
    entries_pending <= product_queue.size();
  end

endmodule

`default_nettype wire

### dv/matrix_multiply_4x4_top_tb.sv
// testbench top for the matrix multiplier: stimulus, stall patterns and verdict
`default_nettype none

module matrix_multiply_4x4_top_tb;
  import mmul4x4_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 200;
  localparam int QUIET_ITEMS  = 50;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req_data  = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp_data;

  int mismatch_count;
  int entries_pending;
  int cycle_count = 0;
  bit no_idle     = 1'b0;

  always #4 clk = ~clk;

  matrix_multiply_4x4_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  matrix_multiply_4x4_top_checker product_check (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_data        (req_data),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp_data        (rsp_data),
    .mismatch_count  (mismatch_count),
    .entries_pending (entries_pending)
  );

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // element value: full range, small, medium or an extreme
  function automatic logic [31:0] pick_value();
    int r;
    logic [31:0] raw;
    r   = $urandom_range(0, 99);
    raw = $urandom();
    if (r < 35) return raw;
    if (r < 75) return {{13{raw[31]}}, raw[18:0]};
    if (r < 88) return {{7{raw[31]}}, raw[24:0]};
    case ($urandom_range(0, 4))
      0: return PRODUCT_MAX;
      1: return PRODUCT_MIN;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // present one request and hold it until taken
  task automatic send_req(logic [1:0] kind, logic [1:0] row, logic [1:0] col,
                          logic [31:0] value);
    int gap;
    req_t r;
    gap = no_idle ? 0 : gap_len();
    r.kind  = kind;
    r.row   = row;
    r.col   = col;
    r.value = value;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // response stall pattern
  initial begin : rsp_stall_driver
    int len;
    forever begin
      len = no_idle ? 0 : gap_len();
      if (len > 0) begin
        rsp_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // cycle limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL matrix_multiply_4x4_top");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    int items;
    int r;
    logic [1:0] side;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: product of the cleared matrices, then ignored kind
    send_req(KIND_MULTIPLY, 2'd0, 2'd0, 32'h0);
    send_req(KIND_UNUSED, 2'd3, 2'd3, 32'hFFFF_FFFF);
    // saturation high at (0,0), low at (1,0)
    send_req(KIND_LOAD_LEFT,  2'd0, 2'd0, PRODUCT_MAX);
    send_req(KIND_LOAD_RIGHT, 2'd0, 2'd0, PRODUCT_MAX);
    send_req(KIND_LOAD_LEFT,  2'd1, 2'd1, PRODUCT_MIN);
    send_req(KIND_LOAD_RIGHT, 2'd1, 2'd0, PRODUCT_MAX);
    // tiny negative term rounds toward minus infinity at (2,3)
    send_req(KIND_LOAD_LEFT,  2'd2, 2'd2, 32'hFFFF_FFFF);
    send_req(KIND_LOAD_RIGHT, 2'd2, 2'd3, 32'h0000_0001);
    // 1.0 times -0.5 on the last entry
    send_req(KIND_LOAD_LEFT,  2'd3, 2'd3, 32'h0001_0000);
    send_req(KIND_LOAD_RIGHT, 2'd3, 2'd3, 32'hFFFF_8000);
    // unused kind must not overwrite an element
    send_req(KIND_UNUSED, 2'd0, 2'd0, 32'h0);
    send_req(KIND_MULTIPLY, 2'd3, 2'd3, 32'h1234_5678);
    // min times min, and a mixed row
    send_req(KIND_LOAD_LEFT,  2'd0, 2'd0, 32'h0);
    send_req(KIND_LOAD_RIGHT, 2'd0, 2'd0, PRODUCT_MIN);
    send_req(KIND_LOAD_LEFT,  2'd0, 2'd1, PRODUCT_MIN);
    send_req(KIND_LOAD_RIGHT, 2'd1, 2'd1, PRODUCT_MIN);
    send_req(KIND_LOAD_LEFT,  2'd1, 2'd0, 32'h7FFF_0000);
    send_req(KIND_LOAD_RIGHT, 2'd0, 2'd2, 32'h8000_FFFF);
    send_req(KIND_MULTIPLY, 2'd1, 2'd2, 32'h0);

    // random: loads, whole-matrix fills, unused kinds and multiplies
    items   = 0;
    no_idle = 1'b1;
    while (items < RANDOM_ITEMS) begin
      if (items >= QUIET_ITEMS) no_idle = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_req(KIND_MULTIPLY, 2'($urandom()), 2'($urandom()), $urandom());
        items++;
      end else if (r < 9) begin
        send_req(KIND_UNUSED, 2'($urandom()), 2'($urandom()), $urandom());
      end else if (r < 12) begin
        side = $urandom_range(0, 1) ? KIND_LOAD_RIGHT : KIND_LOAD_LEFT;
        for (int n = 0; n < 16; n++)
          send_req(side, 2'(n / 4), 2'(n % 4), pick_value());
        items += 16;
      end else begin
        side = $urandom_range(0, 1) ? KIND_LOAD_RIGHT : KIND_LOAD_LEFT;
        send_req(side, 2'($urandom()), 2'($urandom()), pick_value());
        items++;
      end
    end
    send_req(KIND_MULTIPLY, 2'd0, 2'd0, 32'h0);
    req_valid <= 1'b0;

    // drain every owed entry, then watch for strays
    @(posedge clk);
    while (entries_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS matrix_multiply_4x4_top");
    end else begin
      $display("FAIL matrix_multiply_4x4_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
